FILE: hw/rtl/jtvu_pkg.sv
// ============================================================================
// jtvu_pkg: shared types and constants for the JSON text value unescaper
// Beat structs, scan phase codes, status codes and byte classifiers.
// ============================================================================
package jtvu_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int CAP_W          = 16;
    localparam int LEN_W          = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'd256;
    localparam logic [CAP_W-1:0] CAP_MIN   = 16'd8;

    // scan phase codes
    localparam logic [3:0] PH_KEY   = 4'd0;
    localparam logic [3:0] PH_COLON = 4'd1;
    localparam logic [3:0] PH_QUOTE = 4'd2;
    localparam logic [3:0] PH_VALUE = 4'd3;
    localparam logic [3:0] PH_ESC   = 4'd4;
    localparam logic [3:0] PH_HEX   = 4'd5;
    localparam logic [3:0] PH_CONT  = 4'd6;
    localparam logic [3:0] PH_DONE  = 4'd7;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SMALL_CAP = 3'd1;
    localparam logic [2:0] ST_NO_KEY    = 3'd2;
    localparam logic [2:0] ST_MALFORMED = 3'd3;
    localparam logic [2:0] ST_BAD_ESC   = 3'd4;

    // result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [2:0] KEY_LEN   = 3'd6;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       doc_last;
    } in_beat_t;

    typedef struct packed {
        logic             result_kind;
        logic [7:0]       out_byte;
        logic [2:0]       status_code;
        logic [LEN_W-1:0] out_length;
        logic             run_last;
    } out_beat_t;

    typedef struct packed {
        logic [3:0]  phase;
        logic [2:0]  key_pos;
        logic [2:0]  hex_cnt;
        logic [15:0] cp;
        logic [1:0]  pend;
        logic [2:0]  status;
    } state_t;

    localparam state_t STATE_RST = '0;

    // the quoted key "text", one byte per match position
    function automatic logic [7:0] key_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = CH_QUOTE;
            3'd1:    c = 8'h74;
            3'd2:    c = 8'h65;
            3'd3:    c = 8'h78;
            3'd4:    c = 8'h74;
            3'd5:    c = CH_QUOTE;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
    endfunction

    // UTF-8 sequence length from the lead byte; bad leads count as one byte
    function automatic logic [2:0] seq_len(input logic [7:0] lead);
        logic [2:0] n;
        if ((lead & 8'hE0) == 8'hC0)      n = 3'd2;
        else if ((lead & 8'hF0) == 8'hE0) n = 3'd3;
        else if ((lead & 8'hF8) == 8'hF0) n = 3'd4;
        else                              n = 3'd1;
        return n;
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] r;
        if (b >= 8'h30 && b <= 8'h39)      r = {1'b1, 4'(b - 8'h30)};
        else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
        else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
        else                               r = 5'd0;
        return r;
    endfunction

endpackage

FILE: hw/rtl/json_text_value_unescape.sv
// ============================================================================
// json_text_value_unescape: JSON "text" value extractor and unescaper
// Scans a byte stream for the "text" key and emits its decoded UTF-8 value.
// ============================================================================
// Usage:
//   doc channel (doc_valid/doc_stall/doc_beat): one document byte per beat;
//     doc_last or a zero byte ends the document.
//   res channel (res_valid/res_stall/res_beat): decoded data bytes, then one
//     status beat per document (status code and decoded length). run_last
//     flags the final result caused by each input byte.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): out_capacity, always ready;
//     write only while the block is idle.
// Path: an accepted byte is held in the input register, then decoded into
//   the result burst register, from which its first result is offered.
// Throughput: one byte per cycle while res_stall is low and each byte
//   makes at most one result. A byte making k results (a \u escape makes
//   up to three bytes, plus a status) holds the result burst register for
//   k beats; the next byte waits in the input register until one beat is left.
// Reset: capacity returns to 256, the scanner goes back to key search.
// Stall: a stalled result holds; one more byte is taken into the input
//   register, then doc_stall rises.
// ============================================================================
module json_text_value_unescape #(
    parameter int COUNT_BITS = jtvu_pkg::COUNT_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         doc_valid,
    output logic                         doc_stall,
    input  jtvu_pkg::in_beat_t           doc_beat,
    output logic                         res_valid,
    input  logic                         res_stall,
    output jtvu_pkg::out_beat_t          res_beat,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [jtvu_pkg::CAP_W-1:0]   cfg_data
);

    // input register
    logic                       ir_valid_reg;
    jtvu_pkg::in_beat_t         ir_data_reg;

    // scanner state
    jtvu_pkg::state_t           st_reg;
    jtvu_pkg::state_t           st_next;
    logic [COUNT_BITS-1:0]      bw_reg;
    logic [COUNT_BITS-1:0]      bw_next;
    logic [jtvu_pkg::CAP_W-1:0] cap_reg;

    // result burst: slot 0 is the beat on offer
    jtvu_pkg::out_beat_t [3:0]  slot_reg;
    jtvu_pkg::out_beat_t [3:0]  slot_next;
    logic [2:0]                 cnt_reg;
    logic [2:0]                 cnt_next;

    jtvu_pkg::out_beat_t [3:0]  step_res;
    logic [2:0]                 step_cnt;

    logic doc_take;
    logic res_take;
    logic move;

    assign res_valid = (cnt_reg != 3'd0);
    assign res_beat  = slot_reg[0];
    assign res_take  = res_valid && !res_stall;
    assign cfg_ready = 1'b1;

    // the held byte moves into the burst once the burst is empty or about
    // to hand over its last beat
    assign move      = ir_valid_reg && ((cnt_reg == 3'd0) || (cnt_reg == 3'd1 && res_take));
    assign doc_stall = ir_valid_reg && !move;
    assign doc_take  = doc_valid && !doc_stall;

    jtvu_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .cur      (st_reg),
        .bw_cur   (bw_reg),
        .capacity (cap_reg),
        .beat     (ir_data_reg),
        .nxt      (st_next),
        .bw_nxt   (bw_next),
        .res      (step_res),
        .res_cnt  (step_cnt)
    );

    always_comb
    begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (move)
        begin
            slot_next = step_res;
            cnt_next  = step_cnt;
        end
        else if (res_take)
        begin
            for (int i = 0; i < 3; i++)
            begin
                slot_next[i] = slot_reg[i+1];
            end
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_valid_reg <= 1'b0;
            st_reg       <= jtvu_pkg::STATE_RST;
            bw_reg       <= '0;
            cap_reg      <= jtvu_pkg::CAP_RESET;
            cnt_reg      <= 3'd0;
        end
        else
        begin
            if (doc_take)
                ir_valid_reg <= 1'b1;
            else if (move)
                ir_valid_reg <= 1'b0;
            if (move)
            begin
                st_reg <= st_next;
                bw_reg <= bw_next;
            end
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
            cnt_reg <= cnt_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (doc_take)
            ir_data_reg <= doc_beat;
        slot_reg <= slot_next;
    end

    // a burst never holds more than one byte's results
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("result burst overfilled");

    // the last beat in the burst closes its byte's results
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 3'd1) |-> slot_reg[0].run_last)
        else $error("last burst beat lacks run_last");

    // a status beat is always the final result of its byte
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && slot_reg[0].result_kind == jtvu_pkg::KIND_STATUS)
            |-> (slot_reg[0].run_last && cnt_reg == 3'd1))
        else $error("status beat not final");

    // a byte only leaves the input register into a burst that is empty or handing over its last beat
    a_move_clean: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> (cnt_reg == $past(step_cnt)))
        else $error("burst count mismatch after load");

endmodule

FILE: hw/rtl/jtvu_step.sv
// ============================================================================
// jtvu_step: per-byte scanner and decoder
// Combinational next-state and result burst (up to four results) for one byte.
// ============================================================================
module jtvu_step #(
    parameter int COUNT_BITS = jtvu_pkg::COUNT_BITS_DEF
) (
    input  jtvu_pkg::state_t                   cur,
    input  logic [COUNT_BITS-1:0]              bw_cur,
    input  logic [jtvu_pkg::CAP_W-1:0]         capacity,
    input  jtvu_pkg::in_beat_t                 beat,
    output jtvu_pkg::state_t                   nxt,
    output logic [COUNT_BITS-1:0]              bw_nxt,
    output jtvu_pkg::out_beat_t [3:0]          res,
    output logic [2:0]                         res_cnt
);

    localparam int CMP_W = ((COUNT_BITS > jtvu_pkg::CAP_W) ? COUNT_BITS : jtvu_pkg::CAP_W) + 2;

    // fit_ok[n]: n more bytes plus terminator fit in the buffer
    logic [4:1] fit_ok;

    always_comb
    begin
        for (int i = 1; i <= 4; i++)
        begin
            fit_ok[i] = (CMP_W'(bw_cur) + CMP_W'(i) + CMP_W'(1)) <= CMP_W'(capacity);
        end
    end

    always_comb
    begin
        jtvu_pkg::state_t      s;
        logic [7:0]            b;
        logic [2:0][7:0]       db;
        logic [1:0]            nd;
        logic [2:0]            n;
        logic [4:0]            hx;
        logic [15:0]           cpv;
        logic                  esc_simple;
        logic [7:0]            esc_val;
        logic                  ended;
        logic [2:0]            end_st;
        logic [COUNT_BITS-1:0] bw_w;

        s          = cur;
        b          = beat.in_byte;
        db         = '0;
        nd         = 2'd0;
        n          = 3'd1;
        hx         = 5'd0;
        cpv        = 16'd0;
        esc_simple = 1'b0;
        esc_val    = 8'h00;

        if (s.phase != jtvu_pkg::PH_DONE && capacity < jtvu_pkg::CAP_MIN)
        begin
            s.phase  = jtvu_pkg::PH_DONE;
            s.status = jtvu_pkg::ST_SMALL_CAP;
        end

        if (b != 8'h00)
        begin
            case (s.phase)
                jtvu_pkg::PH_KEY:
                begin
                    if (s.key_pos < jtvu_pkg::KEY_LEN && b == jtvu_pkg::key_char(s.key_pos))
                        s.key_pos = s.key_pos + 3'd1;
                    else
                        s.key_pos = (b == jtvu_pkg::CH_QUOTE) ? 3'd1 : 3'd0;
                    if (s.key_pos >= jtvu_pkg::KEY_LEN)
                        s.phase = jtvu_pkg::PH_COLON;
                end
                jtvu_pkg::PH_COLON:
                begin
                    if (b == jtvu_pkg::CH_COLON)
                        s.phase = jtvu_pkg::PH_QUOTE;
                    else if (!jtvu_pkg::is_blank(b))
                    begin
                        s.phase  = jtvu_pkg::PH_DONE;
                        s.status = jtvu_pkg::ST_MALFORMED;
                    end
                end
                jtvu_pkg::PH_QUOTE:
                begin
                    if (b == jtvu_pkg::CH_QUOTE)
                        s.phase = jtvu_pkg::PH_VALUE;
                    else if (!jtvu_pkg::is_blank(b))
                    begin
                        s.phase  = jtvu_pkg::PH_DONE;
                        s.status = jtvu_pkg::ST_MALFORMED;
                    end
                end
                jtvu_pkg::PH_VALUE:
                begin
                    if (b == jtvu_pkg::CH_QUOTE)
                    begin
                        s.phase  = jtvu_pkg::PH_DONE;
                        s.status = jtvu_pkg::ST_OK;
                    end
                    else if (b == jtvu_pkg::CH_BSLASH)
                        s.phase = jtvu_pkg::PH_ESC;
                    else
                    begin
                        n = jtvu_pkg::seq_len(b);
                        if (!fit_ok[n])
                        begin
                            s.phase  = jtvu_pkg::PH_DONE;
                            s.status = jtvu_pkg::ST_OK;
                        end
                        else
                        begin
                            db[0]  = b;
                            nd     = 2'd1;
                            s.pend = 2'(n - 3'd1);
                            if (s.pend != 2'd0)
                                s.phase = jtvu_pkg::PH_CONT;
                        end
                    end
                end
                jtvu_pkg::PH_CONT:
                begin
                    db[0]  = b;
                    nd     = 2'd1;
                    s.pend = s.pend - 2'd1;
                    if (s.pend == 2'd0)
                        s.phase = jtvu_pkg::PH_VALUE;
                end
                jtvu_pkg::PH_ESC:
                begin
                    case (b)
                        jtvu_pkg::CH_QUOTE, jtvu_pkg::CH_BSLASH, 8'h2F:
                        begin
                            esc_simple = 1'b1;
                            esc_val    = b;
                        end
                        8'h62:
                        begin
                            esc_simple = 1'b1;
                            esc_val    = 8'h08;
                        end
                        8'h66:
                        begin
                            esc_simple = 1'b1;
                            esc_val    = 8'h0C;
                        end
                        8'h6E:
                        begin
                            esc_simple = 1'b1;
                            esc_val    = 8'h0A;
                        end
                        8'h72:
                        begin
                            esc_simple = 1'b1;
                            esc_val    = 8'h0D;
                        end
                        8'h74:
                        begin
                            esc_simple = 1'b1;
                            esc_val    = 8'h09;
                        end
                        8'h75:
                        begin
                            s.phase   = jtvu_pkg::PH_HEX;
                            s.hex_cnt = 3'd0;
                            s.cp      = 16'd0;
                        end
                        default:
                        begin
                            s.phase  = jtvu_pkg::PH_DONE;
                            s.status = jtvu_pkg::ST_BAD_ESC;
                        end
                    endcase
                    if (esc_simple)
                    begin
                        if (!fit_ok[1])
                        begin
                            s.phase  = jtvu_pkg::PH_DONE;
                            s.status = jtvu_pkg::ST_OK;
                        end
                        else
                        begin
                            db[0]   = esc_val;
                            nd      = 2'd1;
                            s.phase = jtvu_pkg::PH_VALUE;
                        end
                    end
                end
                jtvu_pkg::PH_HEX:
                begin
                    hx = jtvu_pkg::hex_val(b);
                    if (!hx[4])
                    begin
                        s.phase  = jtvu_pkg::PH_DONE;
                        s.status = jtvu_pkg::ST_BAD_ESC;
                    end
                    else
                    begin
                        s.cp      = {s.cp[11:0], hx[3:0]};
                        s.hex_cnt = s.hex_cnt + 3'd1;
                        if (s.hex_cnt >= 3'd4)
                        begin
                            s.hex_cnt = 3'd0;
                            s.phase   = jtvu_pkg::PH_VALUE;
                            // surrogates are dropped like U+0000
                            cpv = (s.cp >= 16'hD800 && s.cp < 16'hE000) ? 16'd0 : s.cp;
                            if (cpv != 16'd0)
                            begin
                                n = (cpv < 16'h0080) ? 3'd1 : ((cpv < 16'h0800) ? 3'd2 : 3'd3);
                                if (!fit_ok[n])
                                begin
                                    s.phase  = jtvu_pkg::PH_DONE;
                                    s.status = jtvu_pkg::ST_OK;
                                end
                                else if (n == 3'd1)
                                begin
                                    db[0] = cpv[7:0];
                                    nd    = 2'd1;
                                end
                                else if (n == 3'd2)
                                begin
                                    db[0] = 8'hC0 | 8'(cpv[10:6]);
                                    db[1] = 8'h80 | 8'(cpv[5:0]);
                                    nd    = 2'd2;
                                end
                                else
                                begin
                                    db[0] = 8'hE0 | 8'(cpv[15:12]);
                                    db[1] = 8'h80 | 8'(cpv[11:6]);
                                    db[2] = 8'h80 | 8'(cpv[5:0]);
                                    nd    = 2'd3;
                                end
                            end
                            s.cp = 16'd0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        bw_w  = bw_cur + COUNT_BITS'(nd);
        ended = (b == 8'h00) || beat.doc_last;

        case (s.phase)
            jtvu_pkg::PH_KEY:   end_st = jtvu_pkg::ST_NO_KEY;
            jtvu_pkg::PH_COLON: end_st = jtvu_pkg::ST_MALFORMED;
            jtvu_pkg::PH_QUOTE: end_st = jtvu_pkg::ST_MALFORMED;
            jtvu_pkg::PH_ESC:   end_st = jtvu_pkg::ST_BAD_ESC;
            jtvu_pkg::PH_HEX:   end_st = jtvu_pkg::ST_BAD_ESC;
            jtvu_pkg::PH_DONE:  end_st = s.status;
            default:            end_st = jtvu_pkg::ST_OK;
        endcase

        res = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < nd)
            begin
                res[i].result_kind = jtvu_pkg::KIND_DATA;
                res[i].out_byte    = db[i];
            end
        end
        if (ended)
        begin
            res[nd].result_kind = jtvu_pkg::KIND_STATUS;
            res[nd].status_code = end_st;
            res[nd].out_length  = jtvu_pkg::LEN_W'(bw_w);
            s    = jtvu_pkg::STATE_RST;
            bw_w = '0;
        end
        res_cnt = 3'(nd) + 3'(ended);
        for (int i = 0; i < 4; i++)
        begin
            res[i].run_last = (3'(i) + 3'd1 == res_cnt);
        end

        nxt    = s;
        bw_nxt = bw_w;
    end

endmodule

FILE: verif/jtvu_decode_check.sv
// ============================================================================
// jtvu_decode_check: result checker for the JSON text value unescaper
// Watches the doc, res and cfg channels, decodes every accepted document
// byte on its own and compares each result beat field by field.
// ============================================================================
`timescale 1ns / 100ps

module jtvu_decode_check #(
    parameter int COUNT_BITS = jtvu_pkg::COUNT_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       doc_valid,
    input  logic                       doc_stall,
    input  jtvu_pkg::in_beat_t         doc_beat,
    input  logic                       res_valid,
    input  logic                       res_stall,
    input  jtvu_pkg::out_beat_t        res_beat,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [jtvu_pkg::CAP_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         outstanding
);

    // "text" with its quotes, first byte in the top lane
    localparam logic [47:0] TEXT_KEY = {8'h22, 8'h74, 8'h65, 8'h78, 8'h74, 8'h22};

    logic [jtvu_pkg::CAP_W-1:0] capacity;
    logic [3:0]                 phase;
    logic [2:0]                 key_pos;
    logic [2:0]                 hex_cnt;
    logic [15:0]                cp_acc;
    logic [COUNT_BITS-1:0]      written;
    logic [1:0]                 cont_left;
    logic                       full_flag;
    logic [2:0]                 held_status;

    jtvu_pkg::out_beat_t burst[$];
    jtvu_pkg::out_beat_t decoded_q[$];
    int                  errors = 0;

    function automatic logic [2:0] utf8_span(input logic [7:0] lead);
        logic [2:0] n;
        if ((lead & 8'hE0) == 8'hC0)
            n = 3'd2;
        else if ((lead & 8'hF0) == 8'hE0)
            n = 3'd3;
        else if ((lead & 8'hF8) == 8'hF0)
            n = 3'd4;
        else
            n = 3'd1;
        return n;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D;
    endfunction

    // a character of n bytes must still leave room for the terminator
    function automatic logic room_for(input int n);
        return longint'(written) + longint'(n) + 1 <= longint'(capacity);
    endfunction

    function automatic logic [2:0] doc_status();
        case (phase)
            jtvu_pkg::PH_KEY:                     return jtvu_pkg::ST_NO_KEY;
            jtvu_pkg::PH_COLON, jtvu_pkg::PH_QUOTE: return jtvu_pkg::ST_MALFORMED;
            jtvu_pkg::PH_ESC, jtvu_pkg::PH_HEX:   return jtvu_pkg::ST_BAD_ESC;
            jtvu_pkg::PH_DONE:                    return held_status;
            default:                              return jtvu_pkg::ST_OK;
        endcase
    endfunction

    task automatic clear_doc();
        phase       = jtvu_pkg::PH_KEY;
        key_pos     = '0;
        hex_cnt     = '0;
        cp_acc      = '0;
        written     = '0;
        cont_left   = '0;
        full_flag   = 1'b0;
        held_status = jtvu_pkg::ST_OK;
    endtask

    task automatic settle(input logic [2:0] st);
        phase       = jtvu_pkg::PH_DONE;
        held_status = st;
    endtask

    task automatic emit_byte(input logic [7:0] b);
        jtvu_pkg::out_beat_t r;
        r.result_kind = jtvu_pkg::KIND_DATA;
        r.out_byte    = b;
        r.status_code = jtvu_pkg::ST_OK;
        r.out_length  = '0;
        r.run_last    = 1'b0;
        burst.push_back(r);
        written = written + 1'b1;
    endtask

    task automatic emit_code_point(input logic [15:0] cp);
        int n;
        n = (cp < 16'h0080) ? 1 : ((cp < 16'h0800) ? 2 : 3);
        if (!room_for(n))
        begin
            full_flag = 1'b1;
            settle(jtvu_pkg::ST_OK);
        end
        else if (n == 1)
        begin
            emit_byte(cp[7:0]);
        end
        else if (n == 2)
        begin
            emit_byte({3'b110, cp[10:6]});
            emit_byte({2'b10, cp[5:0]});
        end
        else
        begin
            emit_byte({4'b1110, cp[15:12]});
            emit_byte({2'b10, cp[11:6]});
            emit_byte({2'b10, cp[5:0]});
        end
    endtask

    task automatic emit_escaped(input logic [7:0] c);
        if (!room_for(1))
        begin
            full_flag = 1'b1;
            settle(jtvu_pkg::ST_OK);
        end
        else
        begin
            emit_byte(c);
            phase = jtvu_pkg::PH_VALUE;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic [2:0] span;
        logic [3:0] nib;
        logic       is_hex;
        case (phase)
            jtvu_pkg::PH_KEY:
            begin
                if (b == TEXT_KEY[8*(5 - int'(key_pos)) +: 8])
                    key_pos = key_pos + 1'b1;
                else
                    key_pos = (b == jtvu_pkg::CH_QUOTE) ? 3'd1 : 3'd0;
                if (key_pos == jtvu_pkg::KEY_LEN)
                    phase = jtvu_pkg::PH_COLON;
            end
            jtvu_pkg::PH_COLON:
            begin
                if (b == jtvu_pkg::CH_COLON)
                    phase = jtvu_pkg::PH_QUOTE;
                else if (!is_ws(b))
                    settle(jtvu_pkg::ST_MALFORMED);
            end
            jtvu_pkg::PH_QUOTE:
            begin
                if (b == jtvu_pkg::CH_QUOTE)
                    phase = jtvu_pkg::PH_VALUE;
                else if (!is_ws(b))
                    settle(jtvu_pkg::ST_MALFORMED);
            end
            jtvu_pkg::PH_VALUE:
            begin
                if (b == jtvu_pkg::CH_QUOTE)
                begin
                    settle(jtvu_pkg::ST_OK);
                end
                else if (b == jtvu_pkg::CH_BSLASH)
                begin
                    phase = jtvu_pkg::PH_ESC;
                end
                else
                begin
                    span = utf8_span(b);
                    if (!room_for(int'(span)))
                    begin
                        full_flag = 1'b1;
                        settle(jtvu_pkg::ST_OK);
                    end
                    else
                    begin
                        emit_byte(b);
                        cont_left = 2'(span - 3'd1);
                        if (cont_left != 2'd0)
                            phase = jtvu_pkg::PH_CONT;
                    end
                end
            end
            // continuation bytes go out unchecked
            jtvu_pkg::PH_CONT:
            begin
                emit_byte(b);
                cont_left = cont_left - 1'b1;
                if (cont_left == 2'd0)
                    phase = jtvu_pkg::PH_VALUE;
            end
            jtvu_pkg::PH_ESC:
            begin
                case (b)
                    8'h22, 8'h5C, 8'h2F: emit_escaped(b);
                    "b":     emit_escaped(8'h08);
                    "f":     emit_escaped(8'h0C);
                    "n":     emit_escaped(8'h0A);
                    "r":     emit_escaped(8'h0D);
                    "t":     emit_escaped(8'h09);
                    "u":
                    begin
                        phase   = jtvu_pkg::PH_HEX;
                        hex_cnt = '0;
                        cp_acc  = '0;
                    end
                    default: settle(jtvu_pkg::ST_BAD_ESC);
                endcase
            end
            jtvu_pkg::PH_HEX:
            begin
                is_hex = 1'b1;
                nib    = '0;
                if (b >= "0" && b <= "9")
                    nib = 4'(b - "0");
                else if (b >= "a" && b <= "f")
                    nib = 4'(b - "a" + 8'd10);
                else if (b >= "A" && b <= "F")
                    nib = 4'(b - "A" + 8'd10);
                else
                    is_hex = 1'b0;
                if (!is_hex)
                begin
                    settle(jtvu_pkg::ST_BAD_ESC);
                end
                else
                begin
                    cp_acc  = {cp_acc[11:0], nib};
                    hex_cnt = hex_cnt + 1'b1;
                    if (hex_cnt == 3'd4)
                    begin
                        hex_cnt = '0;
                        phase   = jtvu_pkg::PH_VALUE;
                        // surrogates and NUL vanish
                        if (cp_acc >= 16'hD800 && cp_acc < 16'hE000)
                            cp_acc = '0;
                        if (cp_acc != 16'h0000)
                            emit_code_point(cp_acc);
                        cp_acc = '0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic predict_beat(input jtvu_pkg::in_beat_t beat);
        jtvu_pkg::out_beat_t r;
        burst.delete();
        if (phase != jtvu_pkg::PH_DONE && capacity < jtvu_pkg::CAP_MIN)
            settle(jtvu_pkg::ST_SMALL_CAP);
        if (beat.in_byte != 8'h00)
            decode_byte(beat.in_byte);
        if (beat.in_byte == 8'h00 || beat.doc_last)
        begin
            r.result_kind = jtvu_pkg::KIND_STATUS;
            r.out_byte    = 8'h00;
            r.status_code = doc_status();
            r.out_length  = jtvu_pkg::LEN_W'(written);
            r.run_last    = 1'b0;
            burst.push_back(r);
            clear_doc();
        end
        if (burst.size() != 0)
            burst[burst.size() - 1].run_last = 1'b1;
        foreach (burst[i])
            decoded_q.push_back(burst[i]);
    endtask

    // four-state compare so that unknown result bits count as mismatches
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        jtvu_pkg::out_beat_t want;
        if (!rst_n)
        begin
            capacity = jtvu_pkg::CAP_RESET;
            clear_doc();
            decoded_q.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                capacity = cfg_data;
            if (doc_valid && !doc_stall)
                predict_beat(doc_beat);
            if (res_valid && !res_stall)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("result beat with nothing expected: kind %0d byte 0x%0h status %0d",
                           res_beat.result_kind, res_beat.out_byte, res_beat.status_code);
                    errors++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("result_kind", 32'(want.result_kind),
                                32'(res_beat.result_kind));
                    check_field("out_byte", 32'(want.out_byte), 32'(res_beat.out_byte));
                    check_field("status_code", 32'(want.status_code),
                                32'(res_beat.status_code));
                    check_field("out_length", 32'(want.out_length),
                                32'(res_beat.out_length));
                    check_field("run_last", 32'(want.run_last), 32'(res_beat.run_last));
                end
            end
            fail_count  <= errors;
            outstanding <= decoded_q.size();
        end
    end

endmodule

FILE: verif/tb.sv
// ============================================================================
// tb: top level bench for json_text_value_unescape
// Feeds generated JSON documents through several output capacities with
// random idling on both channels; the checker decodes and compares.
// ============================================================================
`timescale 1ns / 100ps

module tb;

    localparam int HOLD_CYCLES   = 200;     // long receiver hold-off
    localparam int SETTLE_CYCLES = 8;       // quiet time before a capacity write
    localparam int DRAIN_CYCLES  = 16;      // tail after the last expected beat
    localparam int QUIET_AT      = 400;     // bytes sent before idling stops
    localparam int CYCLE_LIMIT   = 400000;

    logic                       clk;
    logic                       rst_n     = 1'b0;
    logic                       doc_valid = 1'b0;
    logic                       doc_stall;
    jtvu_pkg::in_beat_t         doc_beat  = '0;
    logic                       res_valid;
    logic                       res_stall = 1'b0;
    jtvu_pkg::out_beat_t        res_beat;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [jtvu_pkg::CAP_W-1:0] cfg_data  = '0;

    int                  fail_count;
    int                  outstanding;
    int                  cycle_count = 0;
    int                  sent = 0;
    logic                quiet = 1'b0;      // no idling on either side once set
    logic                hold_req = 1'b0;   // asks the receiver for one long hold

    jtvu_pkg::in_beat_t  doc_q[$];          // the document being built

    // escape letters the block knows, and some it must reject
    string               esc_ok  = "\"\\/bfnrt";
    string               esc_bad = "aeqxzU0!";
    string               non_hex = "gG/:@`z ";

    json_text_value_unescape DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .doc_valid (doc_valid),
        .doc_stall (doc_stall),
        .doc_beat  (doc_beat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    jtvu_decode_check u_decode_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .doc_valid   (doc_valid),
        .doc_stall   (doc_stall),
        .doc_beat    (doc_beat),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_beat    (res_beat),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog: a hang anywhere ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: short random stall bursts, one long hold on request so the
    // block backs up into doc_stall, and no stalls at all near the end.
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                res_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Document builders. All run in zero time and only append to doc_q.
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        jtvu_pkg::in_beat_t beat;
        beat.in_byte  = b;
        beat.doc_last = 1'b0;
        doc_q.push_back(beat);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic push_blanks();
        repeat ($urandom_range(0, 2))
        begin
            case ($urandom_range(0, 3))
                0:       push_byte(8'h20);
                1:       push_byte(8'h09);
                2:       push_byte(8'h0A);
                default: push_byte(8'h0D);
            endcase
        end
    endtask

    // UTF-8 continuation bytes with random payload
    task automatic push_cont(input int n);
        repeat (n) push_byte({2'b10, 6'($urandom)});
    endtask

    // hex digit, letters in either case
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'(8'h30 + n);
        return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 8'd10);
    endfunction

    task automatic push_hex4(input logic [15:0] v);
        for (int i = 3; i >= 0; i--)
            push_byte(hex_char(v[4*i +: 4]));
    endtask

    // Ends the document: either doc_last on the final byte, or a zero byte
    // (which ends it whatever doc_last says).
    task automatic close_doc();
        if (doc_q.size() == 0 || $urandom_range(0, 3) == 0)
        begin
            push_byte(8'h00);
            doc_q[doc_q.size() - 1].doc_last = 1'($urandom_range(0, 1));
        end
        else
            doc_q[doc_q.size() - 1].doc_last = 1'b1;
    endtask

    // One piece of string value content
    task automatic push_fragment();
        int          k;
        logic [15:0] cp;
        case ($urandom_range(0, 11))
            0, 1, 2:
            begin
                k = $urandom_range(8'h20, 8'h7E);
                if (k == jtvu_pkg::CH_QUOTE || k == jtvu_pkg::CH_BSLASH)
                    k = 8'h61;
                push_byte(8'(k));
            end
            3:
            begin
                push_byte({3'b110, 5'($urandom)});
                push_cont(1);
            end
            4:
            begin
                push_byte({4'b1110, 4'($urandom)});
                push_cont(2);
            end
            5:
            begin
                push_byte({5'b11110, 3'($urandom)});
                push_cont(3);
            end
            // stray continuation or an impossible lead: goes out alone
            6: push_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                              : 8'($urandom_range(8'hF8, 8'hFF)));
            7:
            begin
                push_byte(jtvu_pkg::CH_BSLASH);
                push_byte(esc_ok[$urandom_range(0, esc_ok.len() - 1)]);
            end
            8, 9:
            begin
                case ($urandom_range(0, 4))
                    0:       cp = 16'($urandom_range(16'h0001, 16'h007F));
                    1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
                    2:       cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                    3:       cp = 16'($urandom_range(16'hD800, 16'hDFFF));  // surrogate
                    default: cp = 16'h0000;                                // NUL, dropped
                endcase
                push_byte(jtvu_pkg::CH_BSLASH);
                push_byte(8'h75);
                push_hex4(cp);
            end
            10:
            begin
                push_byte(jtvu_pkg::CH_BSLASH);
                push_byte(esc_bad[$urandom_range(0, esc_bad.len() - 1)]);
            end
            default:
            begin
                // \u with a non-hex digit somewhere in the first four
                push_byte(jtvu_pkg::CH_BSLASH);
                push_byte(8'h75);
                repeat ($urandom_range(0, 3)) push_byte(hex_char(4'($urandom)));
                push_byte(non_hex[$urandom_range(0, non_hex.len() - 1)]);
            end
        endcase
    endtask

    // Mostly well-formed {"text":"..."} documents with random content;
    // the rest is noise, a wrong or restarted key, or broken punctuation.
    task automatic gen_doc();
        int sel;
        doc_q.delete();
        repeat ($urandom_range(0, 3)) push_byte($urandom_range(0, 1) ? 8'h7B : 8'h20);
        sel = $urandom_range(0, 99);
        if (sel < 6)
        begin
            repeat ($urandom_range(1, 10)) push_byte(8'($urandom_range(1, 255)));
            close_doc();
            return;
        end
        if (sel < 11)
            push_text("\"tex\"");            // near miss: key never found
        else if (sel < 15)
            push_text("\"te\"text\"");       // quote restarts the key match
        else
            push_text("\"text\"");
        push_blanks();
        if ($urandom_range(0, 29) == 0)
        begin
            close_doc();                     // ends before the colon
            return;
        end
        push_byte($urandom_range(0, 19) == 0 ? 8'h2C : jtvu_pkg::CH_COLON);
        push_blanks();
        push_byte($urandom_range(0, 19) == 0 ? 8'h78 : jtvu_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 10)) push_fragment();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                // closing quote, then trailing bytes that must be ignored
                push_byte(jtvu_pkg::CH_QUOTE);
                repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(1, 255)));
            end
            6: ;                             // value never closed
            7: push_byte(jtvu_pkg::CH_BSLASH);   // cut right after a backslash
            8:
            begin
                push_byte(jtvu_pkg::CH_BSLASH);  // cut inside \u
                push_byte(8'h75);
                repeat ($urandom_range(0, 3)) push_byte(hex_char(4'($urandom)));
            end
            default:
            begin
                push_byte({4'b1110, 4'($urandom)});  // cut multibyte sequence
                push_cont($urandom_range(0, 1));
            end
        endcase
        close_doc();
    endtask

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Offer one beat and return at the edge that takes it. valid stays up
    // so a following beat can go out back to back.
    task automatic send_beat(input jtvu_pkg::in_beat_t beat);
        if (sent >= QUIET_AT)
            quiet = 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            doc_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        doc_valid <= 1'b1;
        doc_beat  <= beat;
        @(posedge clk);
        while (doc_stall) @(posedge clk);
        sent++;
    endtask

    task automatic send_doc();
        foreach (doc_q[i])
            send_beat(doc_q[i]);
    endtask

    // Drop valid, wait for every predicted beat to come out, then let the
    // block sit idle for the given tail.
    task automatic wait_drained(input int tail);
        doc_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [jtvu_pkg::CAP_W-1:0] cap);
        wait_drained(SETTLE_CYCLES);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One capacity setting, then random documents until the byte budget
    // is spent; squeeze asks the receiver for its long hold-off.
    task automatic run_phase(input logic [jtvu_pkg::CAP_W-1:0] cap, input int budget,
                             input logic squeeze);
        int start;
        write_capacity(cap);
        if (squeeze)
            hold_req = 1'b1;
        start = sent;
        while (sent - start < budget)
        begin
            gen_doc();
            send_doc();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, at the reset capacity of 256.
        // A lone zero byte: empty document, key absent.
        doc_q.delete();
        push_byte(8'h00);
        send_doc();
        // All-ones byte, ended by doc_last or a trailing zero byte: key absent again.
        doc_q.delete();
        push_byte(8'hFF);
        close_doc();
        send_doc();
        // Largest \u value on the final byte: three data beats plus the
        // status beat from a single input.
        doc_q.delete();
        push_text("\"text\":\"\\uFFFF");
        doc_q[doc_q.size() - 1].doc_last = 1'b1;
        send_doc();
        // Key followed by a quote instead of a colon: malformed.
        doc_q.delete();
        push_text("\"text\"\"");
        doc_q[doc_q.size() - 1].doc_last = 1'b1;
        send_doc();

        // Random documents over a spread of capacities: the smallest that
        // works, just below it, zero, the largest, and a few in between.
        run_phase(16'd8, 55, 1'b0);
        run_phase(16'd7, 20, 1'b0);
        run_phase(16'd0, 15, 1'b0);
        run_phase(16'hFFFF, 70, 1'b1);
        run_phase(16'($urandom_range(9, 40)), 60, 1'b0);
        run_phase(jtvu_pkg::CAP_RESET, 45, 1'b0);
        run_phase(16'($urandom_range(12, 300)), 75, 1'b0);

        wait_drained(DRAIN_CYCLES);
        if (fail_count == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
